// ===== rtl/adc_avg_pkg.sv =====
// Shared types and constants of the sample average decimator.
// Used by the divider and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package adc_avg_pkg;

    localparam int WINDOW_LENGTH = 16;

    localparam int SAMPLE_W = 12;
    localparam int VREF_W   = 16;
    localparam int DECIM_W  = 16;
    localparam int SEQ_W    = 32;
    localparam int MV_W     = 16;

    localparam int WIN_AW = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
    localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW_LENGTH);

    localparam logic [WIN_AW-1:0] WIN_LAST = WIN_AW'(WINDOW_LENGTH - 1);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LENGTH);

    localparam int DIV_DEN_W = 12;
    localparam int DIV_Q_W   = 16;
    localparam int DIV_NUM_W = DIV_DEN_W + DIV_Q_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    localparam logic [DIV_DEN_W-1:0] FULL_SCALE = DIV_DEN_W'(4095);
    localparam logic [DIV_NUM_W-1:0] HALF_SCALE = DIV_NUM_W'(2047);

    localparam logic [VREF_W-1:0]  VREF_RESET  = VREF_W'(3300);
    localparam logic [DECIM_W-1:0] DECIM_RESET = DECIM_W'(1);

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (SEQ_W + SAMPLE_W + 2 * MV_W);

    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VREF  = 1'b0,
        CFG_DECIM = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_AVG_DIV,
        ST_RAW_MUL,
        ST_RAW_DIV,
        ST_AVG_MUL,
        ST_MV_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

endpackage

`default_nettype wire

// ===== rtl/adc_avg_ram.sv =====
// Generic single-clock RAM, one write port and one registered read port.
// Self-contained; no package needed.
`timescale 1ns / 1ps
`default_nettype none

module adc_avg_ram #(
    parameter  int WIDTH = 12,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/adc_avg_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on adc_avg_pkg for widths and the request struct.
`timescale 1ns / 1ps
`default_nettype none

module adc_avg_div (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire adc_avg_pkg::t_div_req            i_req,
    output logic                                  o_done,
    output logic [adc_avg_pkg::DIV_Q_W-1:0]       o_quotient
);

    import adc_avg_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_Q_W-1:0]   r_q;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;

    assign trial = {r_rem, r_q[DIV_Q_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.dividend[DIV_NUM_W-1:DIV_Q_W];
            r_q   <= i_req.dividend[DIV_Q_W-1:0];
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            r_q   <= {r_q[DIV_Q_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

// ===== rtl/adc_sample_average_decimator.sv =====
// Moving average of converter samples with decimation and millivolt scaling.
// Each accepted sample updates the window; a sample that emits a record then
// passes through the radix-2 average divider, the raw scale multiply and fold
// by full scale, the average scale multiply and fold, and the output load.
// A new request is taken only in idle, after the last one and its record are done.
// Synchronous active-low reset clears counters, sum and config (3300 mV, factor 1).
`timescale 1ns / 1ps
`default_nettype none

module adc_sample_average_decimator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // config write channel
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [adc_avg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [15:0]                           i_cfg_data,
    // sample requests
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [11:0] sample, [15:12] zero
    input  wire logic [adc_avg_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // records
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [31:0] sequence_res, [43:32] raw_value, [59:44] millivolts,
    // [75:60] average_millivolts, [79:76] zero
    output logic [adc_avg_pkg::OUT_TDATA_W-1:0]        m_axis_tdata
);

    import adc_avg_pkg::*;

    t_state               r_state, n_state;
    logic                 r_div_start, n_div_start;
    logic [VREF_W-1:0]    r_vref;
    logic [DECIM_W-1:0]   r_decim;
    logic [SUM_W-1:0]     r_sum;
    logic [WIN_AW-1:0]    r_pos;
    logic [FILL_W-1:0]    r_fill;
    logic [DECIM_W-1:0]   r_dcnt;
    logic [SEQ_W-1:0]     r_seq;
    logic                 r_out_valid;

    logic [SAMPLE_W-1:0]  r_raw;
    logic [SAMPLE_W-1:0]  r_avg;
    logic [DIV_NUM_W-1:0] r_prod;
    logic [MV_W-1:0]      r_mv_raw;
    logic [MV_W-1:0]      r_mv_avg;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic                 accept;
    logic                 ram_re;
    logic                 ram_we;
    logic                 out_load;
    logic [SAMPLE_W-1:0]  old_sample;

    logic                 full;
    logic [SUM_W-1:0]     n_sum;
    logic [FILL_W-1:0]    n_fill;
    logic [WIN_AW-1:0]    n_pos;
    logic [DECIM_W-1:0]   dcnt_inc;
    logic                 emit;

    t_div_req             div_req;
    logic                 div_done;
    logic [DIV_Q_W-1:0]   div_q;

    // divide by full scale: fold the high part back in twice, then one compare
    function automatic logic [MV_W-1:0] div_full_scale(input logic [DIV_NUM_W-1:0] x);
        logic [DIV_Q_W-1:0]           hi;
        logic [DIV_Q_W:0]             fold1;
        logic [DIV_Q_W-DIV_DEN_W:0]   carry;
        logic [DIV_DEN_W:0]           fold2;
        hi    = x[DIV_NUM_W-1:DIV_DEN_W];
        fold1 = (DIV_Q_W + 1)'(x[DIV_DEN_W-1:0]) + (DIV_Q_W + 1)'(hi);
        carry = fold1[DIV_Q_W:DIV_DEN_W];
        fold2 = (DIV_DEN_W + 1)'(fold1[DIV_DEN_W-1:0]) + (DIV_DEN_W + 1)'(carry);
        return MV_W'(hi) + MV_W'(carry) + MV_W'(fold2 >= {1'b0, FULL_SCALE});
    endfunction

    adc_avg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (WINDOW_LENGTH)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (r_raw),
        .i_re    (ram_re),
        .i_raddr (r_pos),
        .o_rdata (old_sample)
    );

    adc_avg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign accept = s_axis_tvalid && s_axis_tready;

    assign full     = (r_fill == FILL_MAX);
    assign n_sum    = (full ? (r_sum - SUM_W'(old_sample)) : r_sum) + SUM_W'(r_raw);
    assign n_fill   = full ? r_fill : (r_fill + 1'b1);
    assign n_pos    = (r_pos == WIN_LAST) ? '0 : (r_pos + 1'b1);
    assign dcnt_inc = r_dcnt + 1'b1;
    assign emit     = !(dcnt_inc < r_decim);

    always_comb begin
        div_req.start    = r_div_start;
        div_req.dividend = DIV_NUM_W'(r_sum) + DIV_NUM_W'(r_fill >> 1);
        div_req.divisor  = DIV_DEN_W'(r_fill);
    end

    // next state
    always_comb begin
        n_state     = r_state;
        n_div_start = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (emit) begin
                    n_state     = ST_AVG_DIV;
                    n_div_start = 1'b1;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_AVG_DIV: begin
                if (div_done) begin
                    n_state = ST_RAW_MUL;
                end
            end
            ST_RAW_MUL: n_state = ST_RAW_DIV;
            ST_RAW_DIV: n_state = ST_AVG_MUL;
            ST_AVG_MUL: n_state = ST_MV_DIV;
            ST_MV_DIV:  n_state = ST_EMIT;
            ST_EMIT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_axis_tready = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                ram_re        = s_axis_tvalid;
            end
            ST_UPDATE: ram_we = 1'b1;
            ST_EMIT:   out_load = !r_out_valid || m_axis_tready;
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_div_start <= 1'b0;
            r_vref      <= VREF_RESET;
            r_decim     <= DECIM_RESET;
            r_sum       <= '0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_dcnt      <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_div_start <= n_div_start;
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_VREF:  r_vref  <= i_cfg_data;
                    CFG_DECIM: r_decim <= i_cfg_data;
                    default:   r_vref  <= r_vref;
                endcase
            end
            if (r_state == ST_UPDATE) begin
                r_sum  <= n_sum;
                r_fill <= n_fill;
                r_pos  <= n_pos;
                r_seq  <= r_seq + 1'b1;
                r_dcnt <= emit ? '0 : dcnt_inc;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_raw <= s_axis_tdata[SAMPLE_W-1:0];
        end
        if (r_state == ST_AVG_DIV && div_done) begin
            r_avg <= div_q[SAMPLE_W-1:0];
        end
        if (r_state == ST_RAW_MUL) begin
            r_prod <= DIV_NUM_W'(r_raw) * DIV_NUM_W'(r_vref) + HALF_SCALE;
        end
        if (r_state == ST_AVG_MUL) begin
            r_prod <= DIV_NUM_W'(r_avg) * DIV_NUM_W'(r_vref) + HALF_SCALE;
        end
        if (r_state == ST_RAW_DIV) begin
            r_mv_raw <= div_full_scale(r_prod);
        end
        if (r_state == ST_MV_DIV) begin
            r_mv_avg <= div_full_scale(r_prod);
        end
        if (out_load) begin
            r_out_data <= {OUT_PAD_W'(0), r_mv_avg, r_mv_raw, r_raw, r_seq};
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_MAX)
        else $error("fill level beyond window length");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= WIN_LAST)
        else $error("write position beyond window");

    a_sum_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (int'(r_sum) <= int'(r_fill) * 4095))
        else $error("running sum exceeds held samples at full scale");

    a_accept_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_UPDATE))
        else $error("accepted request did not reach window update");

    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_AVG_DIV))
        else $error("divider finished outside the average phase");

endmodule

`default_nettype wire
